>>> hw/rtl/bols_pkg.sv
// Package for the bounded ordered list store.
// Holds opcodes, status codes and the sequencer state type; no dependencies.
package bols_pkg;

  typedef enum logic [2:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_TAIL  = 3'd1,
    OP_ADD_AFTER = 3'd2,
    OP_DEL_EVEN  = 3'd3,
    OP_AVERAGE   = 3'd4,
    OP_DUMP      = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_NOP       = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_EVEN   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SUM,
    S_DIVIDE,
    S_DUMP,
    S_RESULT
  } state_e;

  localparam int unsigned AvgWidth = 40;

endpackage

>>> hw/rtl/bols_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the top level for the average.
module bols_divider #(
  parameter int unsigned NumWidth = 48,
  parameter int unsigned DenWidth = 9
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output logic                done_o,
  output logic [NumWidth-1:0] quot_o
);
  localparam int unsigned CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] quot_q, quot_d;
  logic [DenWidth-1:0] rem_q, rem_d;
  logic [DenWidth-1:0] den_q, den_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [DenWidth:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[NumWidth-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntWidth'(NumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift the next numerator bit into the partial remainder.
      if (trial >= {1'b0, den_q}) begin
        rem_d = DenWidth'(trial - {1'b0, den_q});
        quot_d = {quot_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[DenWidth-1:0];
        quot_d = {quot_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> hw/rtl/bounded_ordered_list_store.sv
// Bounded ordered list store: an ordered list of up to DEPTH signed 32-bit
// values kept in a position-indexed memory with a length count. One beat on
// the slave side carries one operation. Each operation walks the memory
// under a small sequencer, and the block is not ready while it works. For
// inserts, the key search reads one entry per cycle, and shifting the tail
// up reads and then writes each moved entry. Delete-first-even closes the
// hole by reading and then writing each moved entry. A dump reads the next
// entry only once the previous result beat is taken, and an average sums
// the entries and then divides by the length in the bit-serial divider.
// Every operation gives one result beat, except a dump of a non-empty list,
// which gives one beat per entry with tlast on the final one. The memory is
// not cleared at reset; only data read from positions below the length is
// ever used.
module bounded_ordered_list_store #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: opcode[2:0], new_value[34:3], key_value[66:35], zero pad to 72.
  input  logic [71:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: status[2:0], entry_value[34:3], average_fixed[74:35],
  // entry_count[79:75].
  output logic [79:0]  m_axis_tdata_o,
  // tlast: last_result.
  output logic         m_axis_tlast_o
);
  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned LenW    = $clog2(DEPTH + 1);
  localparam int unsigned SumW    = 32 + IdxW + 1;
  localparam int unsigned NumW    = SumW + FRAC_BITS;
  localparam int unsigned AvgW    = bols_pkg::AvgWidth;
  localparam logic [NumW-1:0] PosMax = NumW'({(AvgW-1){1'b1}});
  localparam logic [NumW-1:0] NegMag = NumW'(1) << (AvgW-1);

  bols_pkg::state_e state_q, state_d;
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_q;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  logic [31:0]       wr_data;

  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [2:0]        op_q, op_d;
  logic [31:0]       nv_q, nv_d, key_q, key_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [2:0]        st_q, st_d;
  logic [31:0]       ev_q, ev_d;
  logic [AvgW-1:0]   avg_q, avg_d;
  logic              last_q, last_d;
  logic              ovld_q, ovld_d;

  logic              div_start, div_done;
  logic [NumW-1:0]   div_quot, div_num, qsat;
  logic              neg;
  logic [SumW-1:0]   mag;

  logic              acc;
  logic [2:0]        in_op;

  assign in_op = s_axis_tdata_i[2:0];
  assign acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == bols_pkg::S_IDLE) && !ovld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  assign neg     = sum_q[SumW-1];
  assign mag     = neg ? (SumW'(0) - sum_q) : sum_q;
  assign div_num = NumW'(mag) << FRAC_BITS;

  bols_divider #(.NumWidth(NumW), .DenWidth(LenW)) u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (len_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bols_pkg::S_IDLE: begin
        if (acc) begin
          unique case (bols_pkg::opcode_e'(in_op))
            bols_pkg::OP_ADD_HEAD, bols_pkg::OP_ADD_TAIL:
              state_d = (len_q >= LenW'(DEPTH)) ? bols_pkg::S_RESULT
                                                : bols_pkg::S_SHIFT_UP;
            bols_pkg::OP_ADD_AFTER, bols_pkg::OP_DEL_EVEN:
              state_d = bols_pkg::S_SEARCH;
            bols_pkg::OP_AVERAGE:
              state_d = (len_q == '0) ? bols_pkg::S_RESULT : bols_pkg::S_SUM;
            bols_pkg::OP_DUMP:
              state_d = (len_q == '0) ? bols_pkg::S_RESULT : bols_pkg::S_DUMP;
            default: state_d = bols_pkg::S_RESULT;
          endcase
        end
      end
      bols_pkg::S_SEARCH: begin
        if (op_q == bols_pkg::OP_ADD_AFTER) begin
          if (rd_vld_q && rd_q == key_q)
            state_d = (len_q >= LenW'(DEPTH)) ? bols_pkg::S_RESULT
                                              : bols_pkg::S_SHIFT_UP;
          else if (idx_q >= len_q && !rd_vld_q) state_d = bols_pkg::S_RESULT;
        end else begin
          if (len_q == '0) state_d = bols_pkg::S_RESULT;
          else if (rd_vld_q && !rd_q[0]) state_d = bols_pkg::S_SHIFT_DOWN;
          else if (idx_q >= len_q && !rd_vld_q) state_d = bols_pkg::S_RESULT;
        end
      end
      bols_pkg::S_SHIFT_UP:   if (idx_q == pos_q && !rd_vld_q) state_d = bols_pkg::S_RESULT;
      bols_pkg::S_SHIFT_DOWN: if (idx_q >= len_q && !rd_vld_q) state_d = bols_pkg::S_RESULT;
      bols_pkg::S_SUM:        if (idx_q >= len_q && !rd_vld_q) state_d = bols_pkg::S_DIVIDE;
      bols_pkg::S_DIVIDE:     if (div_done) state_d = bols_pkg::S_RESULT;
      bols_pkg::S_DUMP:       if (ovld_d && last_d) state_d = bols_pkg::S_IDLE;
      bols_pkg::S_RESULT:     state_d = bols_pkg::S_IDLE;
      default:                state_d = bols_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_d = len_q; idx_d = idx_q; rd_vld_d = 1'b0; op_d = op_q;
    nv_d = nv_q; key_d = key_q; pos_d = pos_q; sum_d = sum_q;
    st_d = st_q; ev_d = ev_q; avg_d = avg_q; last_d = last_q;
    ovld_d = ovld_q && !m_axis_tready_i;
    rd_addr = idx_q[IdxW-1:0];
    wr_en = 1'b0; wr_addr = idx_q[IdxW-1:0]; wr_data = rd_q;
    div_start = 1'b0;
    qsat = '0;
    unique case (state_q)
      bols_pkg::S_IDLE: begin
        if (acc) begin
          op_d  = in_op;
          nv_d  = s_axis_tdata_i[34:3];
          key_d = s_axis_tdata_i[66:35];
          st_d  = bols_pkg::ST_OK;
          ev_d  = '0; avg_d = '0; last_d = 1'b1;
          idx_d = '0; sum_d = '0;
          unique case (bols_pkg::opcode_e'(in_op))
            bols_pkg::OP_ADD_HEAD, bols_pkg::OP_ADD_TAIL: begin
              if (len_q >= LenW'(DEPTH)) st_d = bols_pkg::ST_FULL;
              pos_d = (in_op == bols_pkg::OP_ADD_HEAD) ? '0 : len_q;
              idx_d = len_q;
            end
            bols_pkg::OP_AVERAGE, bols_pkg::OP_DUMP:
              if (len_q == '0) st_d = bols_pkg::ST_EMPTY;
            bols_pkg::OP_CLEAR: len_d = '0;
            default: ;
          endcase
        end
      end
      bols_pkg::S_SEARCH: begin
        if (idx_q < len_q) begin
          rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + 1'b1; rd_vld_d = 1'b1;
        end
        if (op_q == bols_pkg::OP_ADD_AFTER) begin
          if (rd_vld_q && rd_q == key_q) begin
            // Key hit at idx_q-1; shift entries above it up by one.
            rd_vld_d = 1'b0;
            if (len_q >= LenW'(DEPTH)) st_d = bols_pkg::ST_FULL;
            pos_d = idx_q; idx_d = len_q;
          end else if (idx_q >= len_q && !rd_vld_q) st_d = bols_pkg::ST_NOT_FOUND;
        end else begin
          if (len_q == '0) st_d = bols_pkg::ST_EMPTY;
          else if (rd_vld_q && !rd_q[0]) begin
            rd_vld_d = 1'b0; idx_d = idx_q - 1'b1;
          end else if (idx_q >= len_q && !rd_vld_q) st_d = bols_pkg::ST_NO_EVEN;
        end
      end
      bols_pkg::S_SHIFT_UP: begin
        // Read idx-1, then write it at idx on the next cycle.
        if (rd_vld_q) begin
          wr_en = 1'b1; wr_addr = idx_q[IdxW-1:0]; wr_data = rd_q;
        end else if (idx_q != pos_q) begin
          rd_addr = IdxW'(idx_q - 1'b1); rd_vld_d = 1'b1;
        end
        if (rd_vld_q) idx_d = idx_q - 1'b1;
        if (idx_q == pos_q && !rd_vld_q) begin
          wr_en = 1'b1; wr_addr = pos_q[IdxW-1:0]; wr_data = nv_q;
          len_d = len_q + 1'b1;
        end
      end
      bols_pkg::S_SHIFT_DOWN: begin
        // idx_q is the hole; copy idx+1 into it. The length drops once, when
        // the hole reaches the tail; the cycle after that only leaves.
        if (rd_vld_q) begin
          wr_en = 1'b1; wr_addr = idx_q[IdxW-1:0]; wr_data = rd_q;
          idx_d = idx_q + 1'b1;
        end else if (idx_q + 1'b1 < len_q) begin
          rd_addr = IdxW'(idx_q + 1'b1); rd_vld_d = 1'b1;
        end else if (idx_q < len_q) begin
          idx_d = len_q; len_d = len_q - 1'b1;
        end
      end
      bols_pkg::S_SUM: begin
        if (idx_q < len_q) begin
          rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + 1'b1; rd_vld_d = 1'b1;
        end
        if (rd_vld_q) sum_d = sum_q + SumW'($signed(rd_q));
        if (idx_q >= len_q && !rd_vld_q) div_start = 1'b1;
      end
      bols_pkg::S_DIVIDE: begin
        if (div_done) begin
          if (neg) begin
            qsat = (div_quot > NegMag) ? NegMag : div_quot;
            avg_d = AvgW'(NumW'(0) - qsat);
          end else begin
            qsat = (div_quot > PosMax) ? PosMax : div_quot;
            avg_d = AvgW'(qsat);
          end
        end
      end
      bols_pkg::S_DUMP: begin
        // One outstanding read at a time, held until the beat is taken.
        if (rd_vld_q) begin
          ev_d = rd_q; last_d = (idx_q == len_q); ovld_d = 1'b1;
        end else if (!ovld_q || m_axis_tready_i) begin
          if (idx_q < len_q) begin
            rd_addr = idx_q[IdxW-1:0]; idx_d = idx_q + 1'b1; rd_vld_d = 1'b1;
          end
        end
      end
      bols_pkg::S_RESULT: ovld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bols_pkg::S_IDLE;
      len_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; nv_q <= nv_d; key_q <= key_d; pos_q <= pos_d;
    sum_q <= sum_d; st_q <= st_d; ev_q <= ev_d; avg_q <= avg_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {5'(len_q), avg_q, ev_q, st_q};
endmodule
